// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the phase table RTL; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NTPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define NTPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ntpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ntpt_pkg
// Types, widths and codes shared by the nearest-timestamp phase table.
// ----------------------------------------------------------------------------
package ntpt_pkg;

  localparam int PHASE_BITS = 16;
  localparam int STAMP_W    = 32;
  localparam int ENTRY_W    = STAMP_W + PHASE_BITS;

  // Stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 3;

  // Request kinds
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [PHASE_BITS-1:0] phase_t;
  typedef logic [STAMP_W-1:0]           stamp_t;

  // Control of the nearest-entry compare unit
  typedef struct packed {
    logic clr;  // start a new search
    logic smp;  // entry on the read data is valid this cycle
  } seek_ctl_t;

endpackage

// ===== rtl/nearest_timestamp_phase_table.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_phase_table
// Two-beam table of timestamped phases with nearest-in-time lookup and
// running per-beam means.
// ----------------------------------------------------------------------------
// An add request stores (stamp, phase) in the chosen beam's RAM and then
// refreshes that beam's mean with a bit-serial divider before the result
// is registered. An add to a full table is dropped at once and answered
// without a divide. A query walks beam one's entries and then beam two's
// through one RAM read port per table and a single distance compare unit,
// one entry a cycle. The block takes one request at a time; the result sits
// in an output register, so the next request can be taken while it waits.
// No clearing pass follows reset: only entries below each count are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_timestamp_phase_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ntpt_pkg::IN_TDATA_W-1:0]      in_tdata,   // stamp, phase_in
  input  logic [ntpt_pkg::IN_TUSER_W-1:0]      in_tuser,   // cmd, beam
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ntpt_pkg::OUT_TDATA_W-1:0]     out_tdata,  // near_b1, near_b2,
                                                           // near_avg, mean_b1,
                                                           // mean_b2, mean_avg
  output logic [ntpt_pkg::OUT_TUSER_W-1:0]     out_tuser   // found_b1, found_b2,
                                                           // add_dropped
);

  localparam int PB    = ntpt_pkg::PHASE_BITS;
  localparam int SW    = ntpt_pkg::STAMP_W;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SUM_W = PB + CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DIVGO = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic                    beam_r, beam_nxt;
  ntpt_pkg::stamp_t        stamp_r, stamp_nxt;
  logic [CNT_W-1:0]        cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic signed [SUM_W-1:0] sum1_r, sum1_nxt, sum2_r, sum2_nxt;
  ntpt_pkg::phase_t        mean1_r, mean1_nxt, mean2_r, mean2_nxt;
  ntpt_pkg::phase_t        near1_r, near1_nxt, near2_r, near2_nxt;
  logic                    found1_r, found1_nxt, found2_r, found2_nxt;
  logic                    drop_r, drop_nxt;
  logic [CNT_W-1:0]        addr_r, addr_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [ntpt_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [ntpt_pkg::OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // Request fields
  logic                    in_acc;
  logic                    in_cmd, in_beam;
  ntpt_pkg::stamp_t        in_stamp;
  ntpt_pkg::phase_t        in_phase;
  logic signed [SUM_W-1:0] phase_ext;
  logic                    full1, full2, in_full;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = in_tuser[0];
  assign in_beam   = in_tuser[1];
  assign in_stamp  = in_tdata[SW-1:0];
  assign in_phase  = ntpt_pkg::phase_t'(in_tdata[SW+PB-1:SW]);
  assign phase_ext = {{(SUM_W-PB){in_phase[PB-1]}}, in_phase};
  assign full1     = (cnt1_r == CNT_W'(TABLE_DEPTH));
  assign full2     = (cnt2_r == CNT_W'(TABLE_DEPTH));
  assign in_full   = in_beam ? full2 : full1;

  // Table RAMs, entry = {phase, stamp}
  logic                         add_ok, we1, we2;
  logic [ntpt_pkg::ENTRY_W-1:0] wdata, rdata1, rdata2, rdata;
  logic [CNT_W-1:0]             cnt_sel;
  logic                         issue, re1, re2, walk_end;

  assign add_ok  = in_acc && (in_cmd == ntpt_pkg::CMD_ADD) && !in_full;
  assign we1     = add_ok && !in_beam;
  assign we2     = add_ok && in_beam;
  assign wdata   = {in_phase, in_stamp};
  assign cnt_sel = beam_r ? cnt2_r : cnt1_r;
  assign issue   = (state_r == S_WALK) && (addr_r < cnt_sel);
  assign re1     = issue && !beam_r;
  assign re2     = issue && beam_r;
  assign rdata   = beam_r ? rdata2 : rdata1;
  assign walk_end = (state_r == S_WALK) && !issue && !rd_pend_r;

  ntpt_ram #(.WIDTH(ntpt_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_b1 (
    .clk   (clk),
    .we    (we1),
    .waddr (cnt1_r[AW-1:0]),
    .wdata (wdata),
    .re    (re1),
    .raddr (addr_r[AW-1:0]),
    .rdata (rdata1)
  );

  ntpt_ram #(.WIDTH(ntpt_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_b2 (
    .clk   (clk),
    .we    (we2),
    .waddr (cnt2_r[AW-1:0]),
    .wdata (wdata),
    .re    (re2),
    .raddr (addr_r[AW-1:0]),
    .rdata (rdata2)
  );

  // Shared nearest-entry compare unit
  ntpt_pkg::seek_ctl_t seek_ctl;
  logic                seek_found;
  ntpt_pkg::phase_t    seek_near;

  assign seek_ctl.clr = in_acc || walk_end;
  assign seek_ctl.smp = rd_pend_r;

  ntpt_seek u_seek (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (seek_ctl),
    .stamp (stamp_r),
    .t_in  (rdata[SW-1:0]),
    .p_in  (ntpt_pkg::phase_t'(rdata[SW+PB-1:SW])),
    .found (seek_found),
    .near  (seek_near)
  );

  // Shared mean divider
  logic             div_start, div_done;
  ntpt_pkg::phase_t div_quo;

  assign div_start = (state_r == S_DIVGO);

  ntpt_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (beam_r ? sum2_r : sum1_r),
    .den   (cnt_sel),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Result fields
  logic [PB:0] near_sum, mean_sum;
  assign near_sum = {near1_r[PB-1], near1_r} + {near2_r[PB-1], near2_r};
  assign mean_sum = {mean1_r[PB-1], mean1_r} + {mean2_r[PB-1], mean2_r};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    beam_nxt       = beam_r;
    stamp_nxt      = stamp_r;
    cnt1_nxt       = cnt1_r;
    cnt2_nxt       = cnt2_r;
    sum1_nxt       = sum1_r;
    sum2_nxt       = sum2_r;
    mean1_nxt      = mean1_r;
    mean2_nxt      = mean2_r;
    near1_nxt      = near1_r;
    near2_nxt      = near2_r;
    found1_nxt     = found1_r;
    found2_nxt     = found2_r;
    drop_nxt       = drop_r;
    addr_nxt       = addr_r;
    rd_pend_nxt    = issue;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          beam_nxt   = in_beam;
          stamp_nxt  = in_stamp;
          near1_nxt  = '0;
          near2_nxt  = '0;
          found1_nxt = 1'b0;
          found2_nxt = 1'b0;
          drop_nxt   = 1'b0;
          addr_nxt   = '0;
          if (in_cmd == ntpt_pkg::CMD_QUERY) begin
            beam_nxt  = 1'b0;
            state_nxt = S_WALK;
          end else if (in_full) begin
            drop_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            // Append and update the running sum
            if (in_beam) begin
              cnt2_nxt = cnt2_r + 1'b1;
              sum2_nxt = sum2_r + phase_ext;
            end else begin
              cnt1_nxt = cnt1_r + 1'b1;
              sum1_nxt = sum1_r + phase_ext;
            end
            state_nxt = S_DIVGO;
          end
        end
      end
      S_WALK: begin
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (walk_end) begin
          if (!beam_r) begin
            near1_nxt  = seek_near;
            found1_nxt = seek_found;
            beam_nxt   = 1'b1;
            addr_nxt   = '0;
          end else begin
            near2_nxt  = seek_near;
            found2_nxt = seek_found;
            state_nxt  = S_OUT;
          end
        end
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (beam_r) begin
            mean2_nxt = div_quo;
          end else begin
            mean1_nxt = div_quo;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {mean_sum[PB:1], mean2_r, mean1_r,
                            near_sum[PB:1], near2_r, near1_r};
          out_tuser_nxt  = {drop_r, found2_r, found1_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt1_r       <= '0;
      cnt2_r       <= '0;
      sum1_r       <= '0;
      sum2_r       <= '0;
      mean1_r      <= '0;
      mean2_r      <= '0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt1_r       <= cnt1_nxt;
      cnt2_r       <= cnt2_nxt;
      sum1_r       <= sum1_nxt;
      sum2_r       <= sum2_nxt;
      mean1_r      <= mean1_nxt;
      mean2_r      <= mean2_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beam_r      <= beam_nxt;
    stamp_r     <= stamp_nxt;
    near1_r     <= near1_nxt;
    near2_r     <= near2_nxt;
    found1_r    <= found1_nxt;
    found2_r    <= found2_nxt;
    drop_r      <= drop_nxt;
    addr_r      <= addr_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Checks
  `NTPT_ASSERT_IMP(a_cnt_bound, 1'b1, (cnt1_r <= CNT_MAX) && (cnt2_r <= CNT_MAX))
  `NTPT_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `NTPT_ASSERT_IMP(a_drop_no_near, out_tvalid && out_tuser[2], out_tdata[47:0] == 48'd0)
  `NTPT_ASSERT_IMP(a_empty_near_zero, out_tvalid && !out_tuser[0], out_tdata[15:0] == 16'd0)

endmodule

// ===== rtl/ntpt_ram.sv =====
// ----------------------------------------------------------------------------
// ntpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ntpt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ntpt_div.sv =====
// ----------------------------------------------------------------------------
// ntpt_div
// Restoring divider, one quotient bit per cycle; signed sum over unsigned
// count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ntpt_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output ntpt_pkg::phase_t        quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int PB     = ntpt_pkg::PHASE_BITS;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [DEN_W:0]    rem_sh;
  logic              ge;
  logic [PB-1:0]     mag;

  // Shift in the next dividend bit, subtract when it fits
  assign rem_sh = {rem_r[DEN_W-1:0], acc_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      rem_nxt  = '0;
      acc_nxt  = num[NUM_W-1] ? (~num + 1'b1) : num;
      den_nxt  = den;
      neg_nxt  = num[NUM_W-1];
    end else if (busy_r) begin
      rem_nxt  = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      acc_nxt  = {acc_r[NUM_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Apply the sign of the sum to the magnitude
  assign mag  = acc_r[PB-1:0];
  assign quo  = neg_r ? ntpt_pkg::phase_t'(~mag + 1'b1) : ntpt_pkg::phase_t'(mag);
  assign done = done_r;

endmodule

// ===== rtl/ntpt_seek.sv =====
// ----------------------------------------------------------------------------
// ntpt_seek
// Nearest-entry tracker: one distance and compare per streamed entry, the
// later entry winning a tie.
// ----------------------------------------------------------------------------
module ntpt_seek (
  input  logic                clk,
  input  logic                rst_n,
  input  ntpt_pkg::seek_ctl_t ctl,
  input  ntpt_pkg::stamp_t    stamp,
  input  ntpt_pkg::stamp_t    t_in,
  input  ntpt_pkg::phase_t    p_in,
  output logic                found,
  output ntpt_pkg::phase_t    near
);

  logic             any_r, any_nxt;
  ntpt_pkg::stamp_t best_r, best_nxt;
  ntpt_pkg::phase_t ph_r, ph_nxt;
  ntpt_pkg::stamp_t span;

  // Absolute time distance
  assign span = (stamp >= t_in) ? (stamp - t_in) : (t_in - stamp);

  always_comb begin
    any_nxt  = any_r;
    best_nxt = best_r;
    ph_nxt   = ph_r;
    if (ctl.clr) begin
      any_nxt = 1'b0;
      ph_nxt  = '0;
    end else if (ctl.smp && (!any_r || span <= best_r)) begin
      any_nxt  = 1'b1;
      best_nxt = span;
      ph_nxt   = p_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
      ph_r  <= '0;
    end else begin
      any_r <= any_nxt;
      ph_r  <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign found = any_r;
  assign near  = ph_r;

endmodule
